FILE: hdl/masked_sprite_blit_with_clip_macros.svh
// ----------------------------------------------------------------------------
// Masked sprite blitter: assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_SPRITE_BLIT_WITH_CLIP_MACROS_SVH
`define MASKED_SPRITE_BLIT_WITH_CLIP_MACROS_SVH

// clocked assertion, quiet while reset is held
`define MSBWC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion, also checked during reset
`define MSBWC_ASSERT_ALL(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/msbwc_pkg.sv
// ----------------------------------------------------------------------------
// Masked sprite blitter package
// Screen and sprite limits, register indexes, queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package msbwc_pkg;

	localparam int SCREEN_WIDTH    = 320;
	localparam int SCREEN_HEIGHT   = 240;
	localparam int MAX_SPRITE_SIDE = 256;

	localparam int CNT_W    = $clog2(MAX_SPRITE_SIDE);
	localparam int POS_W    = 14;
	localparam int SIZE_W   = 9;
	localparam int SPOS_W   = 12;
	localparam int REF_W    = 8;
	localparam int PIX_W    = 8;
	localparam int SX_W     = 9;
	localparam int SY_W     = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_X         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_Y         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_MODE   = 3'd6;

	localparam logic [PIX_W-1:0] SHADOW_ADD = 8'h06;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		KIND_CLIP   = 2'd0,
		KIND_KEEP   = 2'd1,
		KIND_SHADOW = 2'd2,
		KIND_SPRITE = 2'd3
	} blit_kind_t;

	typedef struct packed {
		blit_kind_t       kind;
		logic [SX_W-1:0]  screen_x;
		logic [SY_W-1:0]  screen_y;
		logic [PIX_W-1:0] data;
		logic             last;
	} blit_op_t;

	// last column/row index for a programmed size: 0 reads as 1, clamp at max
	function automatic logic [CNT_W-1:0] side_last(input logic [SIZE_W-1:0] s);
		logic [CNT_W-1:0] r;
		if (s == '0) begin
			r = '0;
		end else if (int'(s) > MAX_SPRITE_SIDE) begin
			r = CNT_W'(MAX_SPRITE_SIDE - 1);
		end else begin
			r = CNT_W'(int'(s) - 1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/msbwc_front.sv
// ----------------------------------------------------------------------------
// Masked sprite blitter: front end
// Holds the registers and raster counters, clips each pixel and classifies it.
// ----------------------------------------------------------------------------
`default_nettype none

module msbwc_front import msbwc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic [PIX_W-1:0]      sprite_pixel,
	input  wire logic [PIX_W-1:0]      screen_pixel,
	input  wire logic [PIX_W-1:0]      background_pixel,
	output      logic                  push,
	output      blit_op_t              push_op,
	input  wire logic                  q_full
);

	logic signed [SPOS_W-1:0] sprite_x_q;
	logic signed [SPOS_W-1:0] sprite_y_q;
	logic [REF_W-1:0]         ref_x_q;
	logic [REF_W-1:0]         ref_y_q;
	logic [SIZE_W-1:0]        width_q;
	logic [SIZE_W-1:0]        height_q;
	logic                     shadow_q;
	logic [CNT_W-1:0]         col_q;
	logic [CNT_W-1:0]         row_q;

	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic                    on_screen;
	logic                    row_end;
	logic                    last;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign push      = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_x_q <= '0;
			sprite_y_q <= '0;
			ref_x_q    <= '0;
			ref_y_q    <= '0;
			width_q    <= SIZE_W'(1);
			height_q   <= SIZE_W'(1);
			shadow_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPRITE_X:      sprite_x_q <= cfg_data[SPOS_W-1:0];
				CFG_SPRITE_Y:      sprite_y_q <= cfg_data[SPOS_W-1:0];
				CFG_REF_X:         ref_x_q    <= cfg_data[REF_W-1:0];
				CFG_REF_Y:         ref_y_q    <= cfg_data[REF_W-1:0];
				CFG_SPRITE_WIDTH:  width_q    <= cfg_data[SIZE_W-1:0];
				CFG_SPRITE_HEIGHT: height_q   <= cfg_data[SIZE_W-1:0];
				CFG_SHADOW_MODE:   shadow_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_x = POS_W'(sprite_x_q) - $signed({{(POS_W-REF_W){1'b0}}, ref_x_q})
			+ $signed({{(POS_W-CNT_W){1'b0}}, col_q});
		pos_y = POS_W'(sprite_y_q) - $signed({{(POS_W-REF_W){1'b0}}, ref_y_q})
			+ $signed({{(POS_W-CNT_W){1'b0}}, row_q});
		on_screen = !pos_x[POS_W-1] && (pos_x < $signed(POS_W'(SCREEN_WIDTH)))
			&& !pos_y[POS_W-1] && (pos_y < $signed(POS_W'(SCREEN_HEIGHT)));
		row_end = col_q >= side_last(width_q);
		last    = row_end && (row_q >= side_last(height_q));
	end

	always_comb begin
		push_op.last = last;
		if (!on_screen) begin
			push_op.kind     = KIND_CLIP;
			push_op.screen_x = '0;
			push_op.screen_y = '0;
			push_op.data     = '0;
		end else begin
			push_op.screen_x = pos_x[SX_W-1:0];
			push_op.screen_y = pos_y[SY_W-1:0];
			if (sprite_pixel == '0) begin
				push_op.kind = KIND_KEEP;
				push_op.data = screen_pixel;
			end else if (shadow_q) begin
				push_op.kind = KIND_SHADOW;
				push_op.data = background_pixel;
			end else begin
				push_op.kind = KIND_SPRITE;
				push_op.data = sprite_pixel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/msbwc_fifo.sv
// ----------------------------------------------------------------------------
// Masked sprite blitter: operation queue
// Short first-in first-out buffer between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module msbwc_fifo import msbwc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire blit_op_t push_op,
	output      logic     full,
	input  wire logic     pop,
	output      blit_op_t pop_op,
	output      logic     not_empty
);

	blit_op_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_ptr_q;
	logic [FIFO_AW-1:0]     rd_ptr_q;
	logic [FIFO_AW:0]       count_q;

	assign full      = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/msbwc_back.sv
// ----------------------------------------------------------------------------
// Masked sprite blitter: back end
// Composes the written pixel and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msbwc_back import msbwc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire blit_op_t         q_op,
	output      logic             pop,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic             write_enable,
	output      logic [SX_W-1:0]  screen_x,
	output      logic [SY_W-1:0]  screen_y,
	output      logic [PIX_W-1:0] pixel_value,
	output      logic             last_pixel
);

	logic             valid_q;
	logic             we_q;
	logic [SX_W-1:0]  sx_q;
	logic [SY_W-1:0]  sy_q;
	logic [PIX_W-1:0] pix_q;
	logic             last_q;
	logic [PIX_W-1:0] pix_d;

	assign pop = q_valid && (!valid_q || out_ready);

	always_comb begin
		case (q_op.kind)
			KIND_CLIP:   pix_d = '0;
			KIND_KEEP:   pix_d = q_op.data;
			KIND_SHADOW: pix_d = q_op.data + SHADOW_ADD;
			KIND_SPRITE: pix_d = q_op.data;
			default:     pix_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			we_q   <= q_op.kind != KIND_CLIP;
			sx_q   <= q_op.screen_x;
			sy_q   <= q_op.screen_y;
			pix_q  <= pix_d;
			last_q <= q_op.last;
		end
	end

	assign out_valid    = valid_q;
	assign write_enable = we_q;
	assign screen_x     = sx_q;
	assign screen_y     = sy_q;
	assign pixel_value  = pix_q;
	assign last_pixel   = last_q;

endmodule

`default_nettype wire

FILE: hdl/masked_sprite_blit_with_clip.sv
// ----------------------------------------------------------------------------
// Masked sprite blitter with clipping
// Places streamed sprite pixels on screen, clips them and applies the mask.
// ----------------------------------------------------------------------------
// One sprite pixel is taken every clock and one result leaves every clock
// while the output is not stalled. The front end (raster counters and clip
// compare) feeds a four-entry queue that the back end drains into a single
// output register, so a stalled output holds up the input only once the
// queue is full. Write registers through the configuration channel only
// while no pixel is in flight (not enforced by the block); the counters
// carry on across writes and return to the first pixel after the last one.
`default_nettype none

module masked_sprite_blit_with_clip import msbwc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [23:0]           s_tdata,  // sprite_pixel, screen_pixel, background_pixel
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [31:0]           m_tdata,  // screen_x, screen_y, pixel_value, zero pad
	output      logic                  m_tuser,  // write_enable
	output      logic                  m_tlast
);

	logic             push;
	blit_op_t         push_op;
	logic             q_full;
	logic             pop;
	blit_op_t         pop_op;
	logic             q_valid;
	logic [SX_W-1:0]  screen_x;
	logic [SY_W-1:0]  screen_y;
	logic [PIX_W-1:0] pixel_value;

	msbwc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.sprite_pixel     (s_tdata[7:0]),
		.screen_pixel     (s_tdata[15:8]),
		.background_pixel (s_tdata[23:16]),
		.push             (push),
		.push_op          (push_op),
		.q_full           (q_full)
	);

	msbwc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (pop),
		.pop_op    (pop_op),
		.not_empty (q_valid)
	);

	msbwc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (pop_op),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.write_enable (m_tuser),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.pixel_value  (pixel_value),
		.last_pixel   (m_tlast)
	);

	assign m_tdata = {7'd0, pixel_value, screen_y, screen_x};

endmodule

`default_nettype wire

FILE: hdl/msbwc_checker.sv
// ----------------------------------------------------------------------------
// Masked sprite blitter: port checker
// Watches the top level's ports for clipping and output register slips.
// ----------------------------------------------------------------------------
`default_nettype none
`include "masked_sprite_blit_with_clip_macros.svh"

module msbwc_checker import msbwc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	`MSBWC_ASSERT_ALL(a_reset_idle, clk, !arst_n |-> !m_tvalid, "output valid during reset")

	`MSBWC_ASSERT_RST(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled transaction changed")

	`MSBWC_ASSERT_RST(a_clip_zero, clk, arst_n, m_tvalid && !m_tuser |-> m_tdata[24:0] == 25'd0, "clipped pixel carries data")

	`MSBWC_ASSERT_RST(a_on_screen, clk, arst_n, m_tvalid && m_tuser |-> (32'(m_tdata[8:0]) < 32'(SCREEN_WIDTH)) && (32'(m_tdata[16:9]) < 32'(SCREEN_HEIGHT)), "written pixel off screen")

endmodule

bind masked_sprite_blit_with_clip msbwc_checker u_msbwc_checker (.*);

`default_nettype wire
